// ===== hdl/binary_cosine_similarity_macros.svh =====
// Assertion macros
`ifndef BINARY_COSINE_SIMILARITY_MACROS_SVH
`define BINARY_COSINE_SIMILARITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: assertion failed");
`define BCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: assertion failed");
`else
`define BCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bcs_pkg.sv =====
`default_nettype none
package bcs_pkg;
	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;
	localparam int unsigned SIM_W = 17;
	localparam int unsigned SIM_ONE = 65536;
	localparam int unsigned SQRT_STEPS = 17;
endpackage
`default_nettype wire

// ===== hdl/bcs_front.sv =====
`default_nettype none
// Classifies input items; drops unused kinds and out-of-range updates, and turns out-of-range queries into kind none.
module bcs_front import bcs_pkg::*; #(
	parameter int unsigned IW = 6,
	parameter int unsigned UW = 8,
	parameter int unsigned NUM_ITEMS = 64,
	parameter int unsigned NUM_USERS = 256
) (
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    in_kind,
	input  wire logic [7:0]    in_user,
	input  wire logic [5:0]    in_ia,
	input  wire logic [5:0]    in_ib,
	output logic               q_push,
	input  wire logic          q_full,
	output logic [1:0]         q_kind,
	output logic [UW-1:0]      q_user,
	output logic [IW-1:0]      q_ia,
	output logic [IW-1:0]      q_ib
);
	logic keep;
	always_comb begin
		in_ready = !q_full;
		keep = 1'b0;
		case (in_kind)
			KIND_ADD, KIND_REMOVE: keep = ({24'd0, in_user} < 32'(NUM_USERS)) &&
				({26'd0, in_ia} < 32'(NUM_ITEMS));
			KIND_QUERY: keep = 1'b1;
			default: keep = 1'b0;
		endcase
		q_push = in_valid && in_ready && keep;
		q_kind = in_kind;
		q_user = UW'(in_user);
		q_ia = IW'(in_ia);
		q_ib = IW'(in_ib);
		if (in_kind == KIND_QUERY && (({26'd0, in_ia} >= 32'(NUM_ITEMS)) ||
				({26'd0, in_ib} >= 32'(NUM_ITEMS))))
			q_kind = KIND_NONE;
	end
endmodule
`default_nettype wire

// ===== hdl/bcs_queue.sv =====
`default_nettype none
// Two-entry FIFO between front and back.
module bcs_queue #(
	parameter int unsigned W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

// ===== hdl/bcs_back.sv =====
`default_nettype none
// Executes updates and queries: watch memory, per-item counts, user scan, sqrt.
module bcs_back import bcs_pkg::*; #(
	parameter int unsigned IW = 6,
	parameter int unsigned UW = 8,
	parameter int unsigned NUM_ITEMS = 64,
	parameter int unsigned NUM_USERS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	output logic              q_pop,
	input  wire logic [1:0]   q_kind,
	input  wire logic [UW-1:0] q_user,
	input  wire logic [IW-1:0] q_ia,
	input  wire logic [IW-1:0] q_ib,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [SIM_W-1:0]  out_sim
);
	localparam int unsigned CW = UW + 1;
	localparam int unsigned NW = 2 * CW;
	localparam int unsigned PW = 2 * SIM_W;
	localparam int unsigned LW = PW + NW;
	localparam int unsigned RW = 2 * CW + 32;
	localparam int unsigned SW = $clog2(SQRT_STEPS + 1);
	localparam int unsigned CLR_N = (NUM_ITEMS > NUM_USERS) ? NUM_ITEMS : NUM_USERS;
	localparam int unsigned SCW = $clog2(CLR_N + 2);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_Q_CNT, ST_Q_ACC,
		ST_Q_MUL, ST_SQ_A, ST_SQ_B, ST_SQ_C, ST_OUT
	} state_t;

	// watch memory: one row of item bits per user
	logic [NUM_ITEMS-1:0] wmem [NUM_USERS];
	logic [NUM_ITEMS-1:0] rd_q;
	// per-item user counts
	logic [CW-1:0] cnt_mem [NUM_ITEMS];
	logic [CW-1:0] cna_q, cnb_q;

	state_t st_q;
	logic [1:0] kind_q;
	logic [UW-1:0] user_q;
	logic [IW-1:0] ia_q, ib_q;
	logic [SCW-1:0] scan_q;
	logic [CW-1:0] na_q, nb_q, com_q;
	logic [NW-1:0] nab_q;
	logic [RW-1:0] rhs_q;
	logic [SIM_W-1:0] s_q, bit_q;
	logic [PW-1:0] sq_q;
	logic [LW-1:0] lhs_q;
	logic [SW-1:0] step_q;
	logic [SIM_W-1:0] res_q;
	logic [SIM_W-1:0] sim_q;
	logic ov_q;

	logic wr_en;
	logic [UW-1:0] wr_addr, rd_addr;
	logic [NUM_ITEMS-1:0] wr_data;
	logic cw_en;
	logic [IW-1:0] cw_addr, ca_addr, cb_addr;
	logic [CW-1:0] cw_data;
	logic [SIM_W-1:0] cand;

	assign cand = s_q | bit_q;
	assign q_pop = (st_q == ST_IDLE) && !q_empty;
	assign out_valid = ov_q;
	assign out_sim = sim_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = user_q;
		wr_data = rd_q;
		cw_en = 1'b0;
		cw_addr = ia_q;
		cw_data = cna_q;
		ca_addr = ia_q;
		cb_addr = ib_q;
		rd_addr = scan_q[UW-1:0];
		case (st_q)
			ST_CLEAR: begin
				wr_en = scan_q < SCW'(NUM_USERS);
				wr_addr = scan_q[UW-1:0];
				wr_data = '0;
				cw_en = scan_q < SCW'(NUM_ITEMS);
				cw_addr = scan_q[IW-1:0];
				cw_data = '0;
			end
			ST_IDLE: begin
				rd_addr = q_user;
				ca_addr = q_ia;
				cb_addr = q_ib;
			end
			ST_UPD_RD: rd_addr = user_q;
			ST_UPD_WR: begin
				rd_addr = user_q;
				wr_en = 1'b1;
				wr_data[ia_q] = (kind_q == KIND_ADD);
				if (kind_q == KIND_ADD && !rd_q[ia_q]) begin
					cw_en = 1'b1;
					cw_data = cna_q + 1'b1;
				end else if (kind_q == KIND_REMOVE && rd_q[ia_q]) begin
					cw_en = 1'b1;
					cw_data = cna_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) wmem[wr_addr] <= wr_data;
		rd_q <= wmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cw_en) cnt_mem[cw_addr] <= cw_data;
		cna_q <= cnt_mem[ca_addr];
		cnb_q <= cnt_mem[cb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			scan_q <= '0;
			ov_q <= 1'b0;
			kind_q <= '0;
			user_q <= '0;
			ia_q <= '0;
			ib_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			com_q <= '0;
			nab_q <= '0;
			rhs_q <= '0;
			s_q <= '0;
			bit_q <= '0;
			sq_q <= '0;
			lhs_q <= '0;
			step_q <= '0;
			res_q <= '0;
			sim_q <= '0;
		end else begin
			if (st_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SCW'(CLR_N - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (!q_empty) begin
					kind_q <= q_kind;
					user_q <= q_user;
					ia_q <= q_ia;
					ib_q <= q_ib;
					scan_q <= '0;
					case (q_kind)
						KIND_ADD, KIND_REMOVE: st_q <= ST_UPD_RD;
						KIND_QUERY: st_q <= ST_Q_CNT;
						default: begin
							res_q <= '0;
							st_q <= ST_OUT;
						end
					endcase
				end
				ST_UPD_RD: st_q <= ST_UPD_WR;
				ST_UPD_WR: st_q <= ST_IDLE;
				ST_Q_CNT: begin
					na_q <= cna_q;
					nb_q <= cnb_q;
					com_q <= '0;
					if (cna_q == '0 || cnb_q == '0) begin
						res_q <= '0;
						st_q <= ST_OUT;
					end else begin
						scan_q <= scan_q + 1'b1;
						st_q <= ST_Q_ACC;
					end
				end
				ST_Q_ACC: begin
					com_q <= com_q + CW'(rd_q[ia_q] & rd_q[ib_q]);
					if (scan_q == SCW'(NUM_USERS)) st_q <= ST_Q_MUL;
					else scan_q <= scan_q + 1'b1;
				end
				ST_Q_MUL: begin
					nab_q <= NW'(na_q) * NW'(nb_q);
					rhs_q <= {RW'(com_q) * RW'(com_q)} << 32;
					s_q <= '0;
					bit_q <= SIM_W'(SIM_ONE);
					step_q <= '0;
					st_q <= ST_SQ_A;
				end
				ST_SQ_A: begin
					sq_q <= PW'(cand) * PW'(cand);
					st_q <= ST_SQ_B;
				end
				ST_SQ_B: begin
					lhs_q <= LW'(sq_q) * LW'(nab_q);
					st_q <= ST_SQ_C;
				end
				ST_SQ_C: begin
					if (LW'(rhs_q) >= lhs_q) s_q <= cand;
					bit_q <= bit_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == SW'(SQRT_STEPS - 1)) begin
						st_q <= ST_OUT;
						res_q <= (LW'(rhs_q) >= lhs_q) ? cand : s_q;
					end else st_q <= ST_SQ_A;
				end
				ST_OUT: if (!ov_q || out_ready) begin
					sim_q <= res_q;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/binary_cosine_similarity.sv =====
`default_nettype none
// Binary cosine similarity: add (kind 0) and remove (kind 1) set or clear one
// watch bit and give no result; a query (kind 2) gives one 17-bit Q1.16 result.
// After reset the block clears its watch memory and item counts over the larger
// of NUM_USERS and NUM_ITEMS addresses before it takes items from the queue. An
// update rewrites the user's watch row and adjusts the item count if the bit
// changes. A query on an item with no users gives 0; any other query scans one
// memory row per cycle, then runs a 17-step square-root search, each step
// passing through ST_SQ_A, ST_SQ_B and ST_SQ_C. A two-entry
// queue sits between the input classifier and the execution unit; s_axis_tready
// drops while it is full, and a result held by m_axis_tready stalls the unit.
module binary_cosine_similarity import bcs_pkg::*; #(
	parameter int unsigned NUM_ITEMS = 64,
	parameter int unsigned NUM_USERS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata, // user[7:0], item_a[13:8], item_b[19:14]
	input  wire logic [1:0]  s_axis_tuser, // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata  // similarity[16:0]
);
	localparam int unsigned IW = (NUM_ITEMS > 64) ? $clog2(NUM_ITEMS) : 6;
	localparam int unsigned UW = (NUM_USERS > 256) ? $clog2(NUM_USERS) : 8;
	localparam int unsigned QW = 2 + UW + 2 * IW;
	logic [19:0] din;
	logic q_push, q_full, q_pop, q_empty;
	logic [1:0] f_kind;
	logic [UW-1:0] f_user;
	logic [IW-1:0] f_ia, f_ib;
	logic [QW-1:0] qr;
	logic [SIM_W-1:0] sim;
	assign din = s_axis_tdata[19:0];
	bcs_front #(.IW(IW), .UW(UW), .NUM_ITEMS(NUM_ITEMS), .NUM_USERS(NUM_USERS)) u_front (
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_user(din[7:0]), .in_ia(din[13:8]), .in_ib(din[19:14]),
		.q_push, .q_full, .q_kind(f_kind), .q_user(f_user), .q_ia(f_ia), .q_ib(f_ib));
	bcs_queue #(.W(QW)) u_queue (.clk, .arst_n, .push(q_push),
		.wdata({f_ib, f_ia, f_user, f_kind}), .full(q_full), .pop(q_pop),
		.empty(q_empty), .rdata(qr));
	bcs_back #(.IW(IW), .UW(UW), .NUM_ITEMS(NUM_ITEMS), .NUM_USERS(NUM_USERS)) u_back (
		.clk, .arst_n, .q_empty, .q_pop, .q_kind(qr[1:0]), .q_user(qr[UW+1:2]),
		.q_ia(qr[UW+IW+1:UW+2]), .q_ib(qr[QW-1:UW+IW+2]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_sim(sim));
	assign m_axis_tdata = {7'd0, sim};
`include "binary_cosine_similarity_macros.svh"
	`BCS_ASSERT_IMP(a_sim_range, clk, arst_n, m_axis_tvalid, sim <= SIM_W'(SIM_ONE))
	`BCS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, !q_empty)
	`BCS_ASSERT_IMP(a_no_push_full, clk, arst_n, q_push, !q_full)
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import bcs_pkg::*;

	localparam int N_ITEMS = 64;
	localparam int N_USERS = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_bus = '0;       // user[7:0], item_a[13:8], item_b[19:14]
	logic [1:0]  s_axis_tuser = '0; // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;      // similarity[16:0]

	binary_cosine_similarity dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_bus),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bit watched [N_USERS][N_ITEMS];
	int unsigned users_of [N_ITEMS];
	logic [16:0] sim_queue [$];
	int errors = 0;
	int n_updates = 0;
	int n_queries = 0;
	int n_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic logic [16:0] cosine(int unsigned ia, int unsigned ib);
		longint unsigned na, nb, common, rhs, s, cand;
		common = 0;
		s = 0;
		na = users_of[ia];
		nb = users_of[ib];
		if (na == 0 || nb == 0)
			return '0;
		for (int u = 0; u < N_USERS; u++)
			if (watched[u][ia] && watched[u][ib])
				common++;
		rhs = (common * common) << 32;
		for (int b = 16; b >= 0; b--) begin
			cand = s | (64'd1 << b);
			if (cand * cand * na * nb <= rhs)
				s = cand;
		end
		if (s > SIM_ONE)
			s = SIM_ONE;
		return s[16:0];
	endfunction

	task automatic apply_transfer(kind_t k, int unsigned u, int unsigned ia, int unsigned ib);
		case (k)
			KIND_ADD: begin
				n_updates++;
				if (!watched[u][ia]) begin
					watched[u][ia] = 1'b1;
					users_of[ia]++;
				end
			end
			KIND_REMOVE: begin
				n_updates++;
				if (watched[u][ia]) begin
					watched[u][ia] = 1'b0;
					users_of[ia]--;
				end
			end
			KIND_QUERY: begin
				n_queries++;
				sim_queue.push_back(cosine(ia, ib));
			end
			default: ;
		endcase
	endtask

	task automatic send_item(kind_t k, int unsigned u, int unsigned ia, int unsigned ib);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 8)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_bus <= {4'd0, ib[5:0], ia[5:0], u[7:0]};
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_transfer(k, u, ia, ib);
	endtask

	task automatic report(string what, logic [16:0] got, logic [16:0] exp_v);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sim_queue.size() == 0) begin
				report("unexpected transfer", m_axis_tdata[16:0], '0);
			end else begin
				logic [16:0] exp_v;
				exp_v = sim_queue.pop_front();
				n_checked++;
				if (m_axis_tdata[16:0] !== exp_v)
					report("similarity", m_axis_tdata[16:0], exp_v);
				if (m_axis_tdata[23:17] !== '0)
					report("pad bits", {10'd0, m_axis_tdata[23:17]}, '0);
			end
		end
	end

	task automatic test_directed();
		send_item(KIND_QUERY, 0, 0, 1);     // empty items
		send_item(KIND_ADD, 0, 0, 0);
		send_item(KIND_ADD, 0, 0, 0);       // repeated add
		send_item(KIND_QUERY, 0, 0, 0);     // same item
		send_item(KIND_QUERY, 0, 0, 63);    // one side empty
		send_item(KIND_ADD, 255, 63, 0);
		send_item(KIND_ADD, 255, 0, 0);
		send_item(KIND_ADD, 7, 63, 0);
		send_item(KIND_QUERY, 0, 63, 0);
		send_item(KIND_QUERY, 0, 0, 63);
		send_item(KIND_REMOVE, 9, 63, 0);   // absent bit
		send_item(KIND_REMOVE, 255, 0, 0);
		send_item(KIND_QUERY, 255, 63, 63);
		send_item(KIND_QUERY, 0, 0, 63);
		send_item(KIND_NONE, 255, 63, 63);
		send_item(KIND_NONE, 0, 0, 0);
		send_item(KIND_ADD, 170, 42, 21);
		send_item(KIND_ADD, 85, 21, 42);
		send_item(KIND_QUERY, 85, 42, 21);
		send_item(KIND_REMOVE, 0, 0, 0);
		send_item(KIND_QUERY, 0, 0, 0);
	endtask

	task automatic test_random(int count);
		int r;
		int unsigned u, ia, ib;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			// mostly a small hot set so items share users
			if ($urandom_range(3) != 0) begin
				u = $urandom_range(31);
				ia = $urandom_range(7);
				ib = $urandom_range(7);
			end else begin
				u = $urandom_range(255);
				ia = $urandom_range(63);
				ib = $urandom_range(63);
			end
			if (r < 45)
				send_item(KIND_ADD, u, ia, ib);
			else if (r < 65)
				send_item(KIND_REMOVE, u, ia, ib);
			else if (r < 97)
				send_item(KIND_QUERY, u, ia, ib);
			else
				send_item(KIND_NONE, u, ia, ib);
		end
	endtask

	initial begin
		foreach (users_of[i])
			users_of[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		send_idle_pct = 23;
		recv_idle_pct = 54;
		test_random(540);
		send_idle_pct = 54;
		recv_idle_pct = 23;
		test_random(540);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(550);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sim_queue.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d updates and %0d queries, %0d results checked",
			n_updates, n_queries, n_checked);
		if (errors == 0 && sim_queue.size() == 0)
			$display("[binary_cosine_similarity] OK");
		else
			$display("[binary_cosine_similarity] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[binary_cosine_similarity] ERROR");
		$finish;
	end
endmodule

// ===== binary_cosine_similarity.f =====
+incdir+hdl
hdl/bcs_pkg.sv
hdl/bcs_front.sv
hdl/bcs_queue.sv
hdl/bcs_back.sv
hdl/binary_cosine_similarity.sv
dv/testbench.sv
